// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at each rising edge, masked while reset is held
`define GPOC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at each rising edge, reset included
`define GPOC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/gpoc_pkg.sv =====
// ----------------------------------------------------------------------------
// gpoc_pkg
// Shared constants, register codes and types of the obstacle centroid core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gpoc_pkg;

  // frame limits
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  // field widths
  localparam int DISP_W     = 12;
  localparam int POS_W      = 10;
  localparam int PROD_W     = 22;
  localparam int SLOPE_W    = 17;
  localparam int PLANE_W    = 16;
  localparam int OFF_W      = 12;
  localparam int SCALE_W    = 16;
  localparam int CNT_W      = 21;
  localparam int SUM_W      = 32;
  localparam int MOM_W      = 42;
  localparam int NUM_W      = 41;
  localparam int SPROD_W    = SCALE_W + CNT_W;
  localparam int DIST_W     = 20;
  localparam int CTR_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // ground plane compare
  localparam int SLOPE_PROD_W = SLOPE_W + POS_W + 1;
  localparam int GROUND_W     = 30;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // divider
  localparam int DIV_STEPS = NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(12000);
  localparam logic [CTR_W-1:0]   CTR_MAX     = '1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOPE     = 3'd0,
    CFG_INTERCEPT = 3'd1,
    CFG_MARGIN    = 3'd2,
    CFG_COL_OFF   = 3'd3,
    CFG_ROW_OFF   = 3'd4,
    CFG_SCALE     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [SLOPE_W-1:0] slope;
    logic [PLANE_W-1:0] intercept;
    logic [PLANE_W-1:0] margin;
    logic [OFF_W-1:0]   col_off;
    logic [OFF_W-1:0]   row_off;
    logic [SCALE_W-1:0] scale;
  } cfg_t;

  // one classified pixel
  typedef struct packed {
    logic              hit;
    logic              last;
    logic [DISP_W-1:0] disp;
    logic [PROD_W-1:0] pcol;
    logic [PROD_W-1:0] prow;
  } q_entry_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [SUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/gpoc_queue.sv =====
// ----------------------------------------------------------------------------
// gpoc_queue
// Short first-in first-out queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpoc_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire gpoc_pkg::q_entry_t wdata,
  input  wire logic               pop,
  output gpoc_pkg::q_entry_t      rdata,
  output logic                    full,
  output logic                    empty
);

  gpoc_pkg::q_entry_t slot_r [gpoc_pkg::QUEUE_DEPTH];

  logic [gpoc_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [gpoc_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [gpoc_pkg::QPTR_W:0]   count_r;

  // status
  assign full  = (count_r == (gpoc_pkg::QPTR_W+1)'(gpoc_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = slot_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gpoc_front.sv =====
// ----------------------------------------------------------------------------
// gpoc_front
// Accepts pixels, tests them against region, frame and ground plane, and
// forms the column and row weighted products for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpoc_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [gpoc_pkg::DISP_W-1:0]   in_disparity,
  input  wire logic [gpoc_pkg::POS_W-1:0]    in_row,
  input  wire logic [gpoc_pkg::POS_W-1:0]    in_col,
  input  wire logic                          in_inside_region,
  input  wire logic                          in_frame_end,
  input  wire gpoc_pkg::cfg_t                cfg,
  input  wire logic                          q_full,
  output logic                               q_push,
  output gpoc_pkg::q_entry_t                 q_wdata
);

  logic                                      fs_v_r;
  logic [gpoc_pkg::DISP_W-1:0]               d_r;
  logic [gpoc_pkg::POS_W-1:0]                row_r;
  logic [gpoc_pkg::POS_W-1:0]                col_r;
  logic                                      ins_r;
  logic                                      last_r;
  logic signed [gpoc_pkg::SLOPE_PROD_W-1:0]  slope_prod_r;

  logic signed [gpoc_pkg::PLANE_W:0]         base;
  logic signed [gpoc_pkg::GROUND_W-1:0]      ground;
  logic signed [gpoc_pkg::GROUND_W-1:0]      dsh;
  logic signed [gpoc_pkg::PROD_W:0]          pcol_w;
  logic signed [gpoc_pkg::PROD_W:0]          prow_w;
  logic                                      row_ok;
  logic                                      col_ok;
  logic                                      above;

  // stage holds while the queue is full
  assign in_stall = fs_v_r & q_full;
  assign q_push   = fs_v_r & ~q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_v_r <= 1'b0;
    end else if (!in_stall) begin
      fs_v_r <= in_valid;
    end
  end

  // capture pixel and slope times row
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      d_r          <= in_disparity;
      row_r        <= in_row;
      col_r        <= in_col;
      ins_r        <= in_inside_region;
      last_r       <= in_frame_end;
      slope_prod_r <= $signed(cfg.slope) * $signed({1'b0, in_row});
    end
  end

  // ground plane line at this row, in 1/256 sixteenths
  always_comb begin
    base   = $signed({cfg.intercept[gpoc_pkg::PLANE_W-1], cfg.intercept})
           + $signed({cfg.margin[gpoc_pkg::PLANE_W-1], cfg.margin});
    ground = $signed({{5{base[gpoc_pkg::PLANE_W]}}, base, 8'b0})
           + $signed({{2{slope_prod_r[gpoc_pkg::SLOPE_PROD_W-1]}}, slope_prod_r});
    dsh    = $signed({{10{d_r[gpoc_pkg::DISP_W-1]}}, d_r, 8'b0});
    above  = (dsh >= ground);
    row_ok = ({22'b0, row_r} < 32'(gpoc_pkg::MAX_ROWS));
    col_ok = ({22'b0, col_r} < 32'(gpoc_pkg::MAX_COLS));
  end

  // weighted products
  always_comb begin
    pcol_w = $signed(d_r) * $signed({1'b0, col_r});
    prow_w = $signed(d_r) * $signed({1'b0, row_r});
  end

  always_comb begin
    q_wdata.hit  = ins_r && (d_r != '0) && row_ok && col_ok && above;
    q_wdata.last = last_r;
    q_wdata.disp = d_r;
    q_wdata.pcol = pcol_w[gpoc_pkg::PROD_W-1:0];
    q_wdata.prow = prow_w[gpoc_pkg::PROD_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/core/gpoc_div.sv =====
// ----------------------------------------------------------------------------
// gpoc_div
// Restoring divider, one quotient bit per cycle, shared by the three
// end-of-frame quotients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpoc_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire gpoc_pkg::div_req_t req,
  output gpoc_pkg::div_rsp_t      rsp
);

  logic [gpoc_pkg::NUM_W-1:0]     q_r;
  logic [gpoc_pkg::SUM_W-1:0]     rem_r;
  logic [gpoc_pkg::SUM_W-1:0]     den_r;
  logic [gpoc_pkg::DIV_CNT_W-1:0] step_r;
  logic                           busy_r;
  logic                           done_r;

  logic [gpoc_pkg::SUM_W:0]       rem_sh;
  logic [gpoc_pkg::SUM_W:0]       rem_sub;
  logic                           ge;

  // trial subtract
  always_comb begin
    rem_sh  = {rem_r, q_r[gpoc_pkg::NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    ge      = (rem_sh >= {1'b0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == gpoc_pkg::DIV_CNT_W'(gpoc_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[gpoc_pkg::NUM_W-2:0], ge};
      rem_r <= ge ? rem_sub[gpoc_pkg::SUM_W-1:0] : rem_sh[gpoc_pkg::SUM_W-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;

endmodule

`default_nettype wire

// ===== rtl/core/gpoc_back.sv =====
// ----------------------------------------------------------------------------
// gpoc_back
// Accumulates counted pixels; at frame end with an object it works out
// distance and centroid through the shared divider, and presents the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpoc_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  input  wire gpoc_pkg::q_entry_t          q_rdata,
  output logic                             q_pop,
  input  wire gpoc_pkg::cfg_t              cfg,
  output gpoc_pkg::div_req_t               div_req,
  input  wire gpoc_pkg::div_rsp_t          div_rsp,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_object_found,
  output logic [gpoc_pkg::DIST_W-1:0]      out_distance_cm,
  output logic [gpoc_pkg::CTR_W-1:0]       out_center_x,
  output logic [gpoc_pkg::CTR_W-1:0]       out_center_y
);

  typedef enum logic [1:0] {
    S_ACC,
    S_CHK,
    S_DIV,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    DIV_DIST,
    DIV_COLX,
    DIV_ROWY
  } div_sel_t;

  state_t                        state_r;
  div_sel_t                      sel_r;
  logic                          div_start_r;
  logic                          div_start_nxt;

  logic [gpoc_pkg::CNT_W-1:0]    cnt_r;
  logic [gpoc_pkg::SUM_W-1:0]    sum_r;
  logic [gpoc_pkg::MOM_W-1:0]    mc_r;
  logic [gpoc_pkg::MOM_W-1:0]    mr_r;

  logic [gpoc_pkg::CNT_W-1:0]    fcnt_r;
  logic [gpoc_pkg::SUM_W-1:0]    fsum_r;
  logic [gpoc_pkg::MOM_W-1:0]    fmc_r;
  logic [gpoc_pkg::MOM_W-1:0]    fmr_r;
  logic [gpoc_pkg::SPROD_W-1:0]  sprod_r;

  logic                          res_found_r;
  logic [gpoc_pkg::DIST_W-1:0]   res_dist_r;
  logic [gpoc_pkg::CTR_W-1:0]    res_x_r;
  logic [gpoc_pkg::CTR_W-1:0]    res_y_r;

  logic                          out_valid_r;
  logic                          out_found_r;
  logic [gpoc_pkg::DIST_W-1:0]   out_dist_r;
  logic [gpoc_pkg::CTR_W-1:0]    out_x_r;
  logic [gpoc_pkg::CTR_W-1:0]    out_y_r;

  logic [gpoc_pkg::CNT_W-1:0]    cnt_upd;
  logic [gpoc_pkg::SUM_W-1:0]    sum_upd;
  logic [gpoc_pkg::MOM_W-1:0]    mc_upd;
  logic [gpoc_pkg::MOM_W-1:0]    mr_upd;
  logic                          found_c;
  logic [gpoc_pkg::NUM_W-1:0]    num_c;

  // clamp a quotient to the centre range, add the crop offset, clamp again
  function automatic logic [gpoc_pkg::CTR_W-1:0] centre_of(
    input logic [gpoc_pkg::NUM_W-1:0] quo,
    input logic [gpoc_pkg::OFF_W-1:0] off
  );
    logic [gpoc_pkg::CTR_W-1:0] q13;
    logic [gpoc_pkg::CTR_W:0]   s14;
    q13 = (|quo[gpoc_pkg::NUM_W-1:gpoc_pkg::CTR_W]) ? gpoc_pkg::CTR_MAX
                                                    : quo[gpoc_pkg::CTR_W-1:0];
    s14 = {1'b0, q13} + {2'b0, off};
    return s14[gpoc_pkg::CTR_W] ? gpoc_pkg::CTR_MAX : s14[gpoc_pkg::CTR_W-1:0];
  endfunction

  assign q_pop = (state_r == S_ACC) && !q_empty;

  // accumulators with the head pixel folded in
  always_comb begin
    cnt_upd = cnt_r;
    sum_upd = sum_r;
    mc_upd  = mc_r;
    mr_upd  = mr_r;
    if (q_rdata.hit) begin
      cnt_upd = cnt_r + 1'b1;
      sum_upd = sum_r + {{20{q_rdata.disp[gpoc_pkg::DISP_W-1]}}, q_rdata.disp};
      mc_upd  = mc_r + {{20{q_rdata.pcol[gpoc_pkg::PROD_W-1]}}, q_rdata.pcol};
      mr_upd  = mr_r + {{20{q_rdata.prow[gpoc_pkg::PROD_W-1]}}, q_rdata.prow};
    end
  end

  // object present: pixels counted and a positive disparity sum
  assign found_c = (fcnt_r != '0) && !fsum_r[gpoc_pkg::SUM_W-1] && (fsum_r != '0);

  // dividend for the current quotient; a negative moment counts as zero
  always_comb begin
    unique case (sel_r)
      DIV_DIST: num_c = {sprod_r, 4'b0};
      DIV_COLX: num_c = fmc_r[gpoc_pkg::MOM_W-1] ? '0 : fmc_r[gpoc_pkg::NUM_W-1:0];
      DIV_ROWY: num_c = fmr_r[gpoc_pkg::MOM_W-1] ? '0 : fmr_r[gpoc_pkg::NUM_W-1:0];
      default:  num_c = '0;
    endcase
  end

  // divider start: first quotient on an object, then after distance and column
  always_comb begin
    div_start_nxt = 1'b0;
    if (state_r == S_CHK) begin
      div_start_nxt = found_c;
    end else if (state_r == S_DIV && div_rsp.done &&
                 (sel_r == DIV_DIST || sel_r == DIV_COLX)) begin
      div_start_nxt = 1'b1;
    end
  end

  assign div_req.start = div_start_r;
  assign div_req.num   = num_c;
  assign div_req.den   = fsum_r;

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      sel_r       <= DIV_DIST;
      div_start_r <= 1'b0;
      cnt_r       <= '0;
      sum_r       <= '0;
      mc_r        <= '0;
      mr_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= div_start_nxt;
      // result valid: set when the end state loads it, cleared once transferred
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_ACC: begin
          if (!q_empty) begin
            if (q_rdata.last) begin
              fcnt_r  <= cnt_upd;
              fsum_r  <= sum_upd;
              fmc_r   <= mc_upd;
              fmr_r   <= mr_upd;
              cnt_r   <= '0;
              sum_r   <= '0;
              mc_r    <= '0;
              mr_r    <= '0;
              state_r <= S_CHK;
            end else begin
              cnt_r <= cnt_upd;
              sum_r <= sum_upd;
              mc_r  <= mc_upd;
              mr_r  <= mr_upd;
            end
          end
        end
        S_CHK: begin
          res_found_r <= found_c;
          res_dist_r  <= '0;
          res_x_r     <= '0;
          res_y_r     <= '0;
          sprod_r     <= gpoc_pkg::SPROD_W'(cfg.scale) * gpoc_pkg::SPROD_W'(fcnt_r);
          sel_r       <= DIV_DIST;
          if (found_c) begin
            state_r <= S_DIV;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            unique case (sel_r)
              DIV_DIST: begin
                res_dist_r <= (|div_rsp.quo[gpoc_pkg::NUM_W-1:gpoc_pkg::DIST_W])
                              ? '1 : div_rsp.quo[gpoc_pkg::DIST_W-1:0];
                sel_r      <= DIV_COLX;
              end
              DIV_COLX: begin
                res_x_r <= centre_of(div_rsp.quo, cfg.col_off);
                sel_r   <= DIV_ROWY;
              end
              DIV_ROWY: begin
                res_y_r <= centre_of(div_rsp.quo, cfg.row_off);
                state_r <= S_OUT;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_found_r <= res_found_r;
            out_dist_r  <= res_dist_r;
            out_x_r     <= res_x_r;
            out_y_r     <= res_y_r;
            state_r     <= S_ACC;
          end
        end
        default: state_r <= S_ACC;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_object_found = out_found_r;
  assign out_distance_cm  = out_dist_r;
  assign out_center_x     = out_x_r;
  assign out_center_y     = out_y_r;

endmodule

`default_nettype wire

// ===== rtl/core/ground_plane_obstacle_centroid_core.sv =====
// Throughput: one pixel per cycle while the back end accumulates.
// At frame end a result with no object needs no division; one with an object needs
// three 41-step divisions on the shared divider. While those divisions run, the
// 4-entry queue fills and the input then stalls.
// Reset: synchronous, active low; clears accumulators, queue and handshakes,
// and loads register defaults (range scale 12000, all others zero).
// ----------------------------------------------------------------------------
// ground_plane_obstacle_centroid_core
// Top level: configuration registers, front classifier, pixel queue, back end
// accumulator and shared divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ground_plane_obstacle_centroid_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [gpoc_pkg::DISP_W-1:0]      in_disparity,
  input  wire logic [gpoc_pkg::POS_W-1:0]       in_row,
  input  wire logic [gpoc_pkg::POS_W-1:0]       in_col,
  input  wire logic                             in_inside_region,
  input  wire logic                             in_frame_end,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_object_found,
  output logic [gpoc_pkg::DIST_W-1:0]           out_distance_cm,
  output logic [gpoc_pkg::CTR_W-1:0]            out_center_x,
  output logic [gpoc_pkg::CTR_W-1:0]            out_center_y,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [gpoc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gpoc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  gpoc_pkg::cfg_t     cfg_r;
  gpoc_pkg::q_entry_t q_wdata;
  gpoc_pkg::q_entry_t q_rdata;
  gpoc_pkg::div_req_t div_req;
  gpoc_pkg::div_rsp_t div_rsp;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slope     <= '0;
      cfg_r.intercept <= '0;
      cfg_r.margin    <= '0;
      cfg_r.col_off   <= '0;
      cfg_r.row_off   <= '0;
      cfg_r.scale     <= gpoc_pkg::SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gpoc_pkg::CFG_SLOPE:     cfg_r.slope     <= cfg_data[gpoc_pkg::SLOPE_W-1:0];
        gpoc_pkg::CFG_INTERCEPT: cfg_r.intercept <= cfg_data[gpoc_pkg::PLANE_W-1:0];
        gpoc_pkg::CFG_MARGIN:    cfg_r.margin    <= cfg_data[gpoc_pkg::PLANE_W-1:0];
        gpoc_pkg::CFG_COL_OFF:   cfg_r.col_off   <= cfg_data[gpoc_pkg::OFF_W-1:0];
        gpoc_pkg::CFG_ROW_OFF:   cfg_r.row_off   <= cfg_data[gpoc_pkg::OFF_W-1:0];
        gpoc_pkg::CFG_SCALE:     cfg_r.scale     <= cfg_data[gpoc_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // pixel classifier
  gpoc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_disparity     (in_disparity),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_inside_region (in_inside_region),
    .in_frame_end     (in_frame_end),
    .cfg              (cfg_r),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_wdata          (q_wdata)
  );

  // decoupling queue
  gpoc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // shared divider
  gpoc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // accumulation and end-of-frame results
  gpoc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .cfg              (cfg_r),
    .div_req          (div_req),
    .div_rsp          (div_rsp),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_object_found (out_object_found),
    .out_distance_cm  (out_distance_cm),
    .out_center_x     (out_center_x),
    .out_center_y     (out_center_y)
  );

endmodule

`default_nettype wire

// ===== rtl/core/gpoc_checker.sv =====
// ----------------------------------------------------------------------------
// gpoc_checker
// Port-level checks of the obstacle centroid core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gpoc_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic                             out_object_found,
  input wire logic [gpoc_pkg::DIST_W-1:0]      out_distance_cm,
  input wire logic [gpoc_pkg::CTR_W-1:0]       out_center_x,
  input wire logic [gpoc_pkg::CTR_W-1:0]       out_center_y
);

  // a stalled result stays put
  `GPOC_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_object_found) && $stable(out_distance_cm) && $stable(out_center_x) && $stable(out_center_y), "stalled result changed")

  // no object means all values zero
  `GPOC_ASSERT(a_none_zero, clk, rst_n, out_valid && !out_object_found |-> out_distance_cm == '0 && out_center_x == '0 && out_center_y == '0, "no-object result carries values")

  // nothing offered straight after reset
  `GPOC_ASSERT_NR(a_rst_out, clk, rst_n && $past(!rst_n) |-> !out_valid, "result valid after reset")

  // input open straight after reset
  `GPOC_ASSERT_NR(a_rst_in, clk, rst_n && $past(!rst_n) |-> !in_stall, "input stalled after reset")

endmodule

bind ground_plane_obstacle_centroid_core gpoc_checker u_gpoc_checker (.*);

`default_nettype wire

// ===== bench/ground_plane_obstacle_centroid_core_test.sv =====
// ----------------------------------------------------------------------------
// ground_plane_obstacle_centroid_core_test
// Self-checking bench for the obstacle centroid core. A queue of pixels feeds
// a clocked driver. Every accepted pixel is classified against the ground
// plane and accumulated in a local copy of the frame state, and each frame
// end queues the expected centroid. A clocked monitor compares the core's
// results field by field. Directed frames come first, then random planes
// and frames, with random idling, one long output hold-off and one calm
// phase with no idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ground_plane_obstacle_centroid_core_test;
  import gpoc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES = 600;
  localparam int IDLE_PCT = 23;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [DISP_W-1:0] disp;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              roi;
    logic              last;
  } pixel_t;

  typedef struct packed {
    logic              found;
    logic [DIST_W-1:0] dist_cm;
    logic [CTR_W-1:0]  cx;
    logic [CTR_W-1:0]  cy;
  } centroid_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [DISP_W-1:0]     in_disparity = '0;
  logic [POS_W-1:0]      in_row = '0;
  logic [POS_W-1:0]      in_col = '0;
  logic                  in_inside_region = 1'b0;
  logic                  in_frame_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_object_found;
  logic [DIST_W-1:0]     out_distance_cm;
  logic [CTR_W-1:0]      out_center_x;
  logic [CTR_W-1:0]      out_center_y;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // local copy of the plane registers
  logic signed [SLOPE_W-1:0] slope_m = '0;
  logic signed [PLANE_W-1:0] icpt_m = '0;
  logic signed [PLANE_W-1:0] margin_m = '0;
  logic [OFF_W-1:0]          coff_m = '0;
  logic [OFF_W-1:0]          roff_m = '0;
  logic [SCALE_W-1:0]        scale_m = SCALE_RESET;

  // local copy of the frame accumulators
  logic [CNT_W-1:0] pix_cnt = '0;
  logic [SUM_W-1:0] disp_sum = '0;
  logic [MOM_W-1:0] mom_col = '0;
  logic [MOM_W-1:0] mom_row = '0;

  pixel_t    pixel_q[$];
  centroid_t centroid_q[$];
  pixel_t    cur_px;
  int        n_queued = 0;
  int        n_accepted = 0;
  int        mismatches = 0;
  int        cycles = 0;
  int        hold_left = 0;
  bit        calm = 1'b0;
  bit        choke_req = 1'b0;
  bit        choke_taken = 1'b0;

  ground_plane_obstacle_centroid_core dut (.*);

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // centroid coordinate: clamp negative moments to zero, saturate
  function automatic logic [CTR_W-1:0] centroid_coord(logic [MOM_W-1:0] mom, longint sum,
                                                     logic [OFF_W-1:0] off);
    longint m, q;
    m = longint'($signed(mom));
    q = (m > 0) ? m / sum : 0;
    if (q > 8191) q = 8191;
    q = q + longint'(off);
    return (q > 8191) ? CTR_MAX : CTR_W'(q);
  endfunction

  // classify one pixel, accumulate it, and queue a centroid at frame end
  function automatic void accumulate_pixel(pixel_t p);
    longint    d, ground, sum, range_cm;
    centroid_t res;
    d = longint'($signed(p.disp));
    if (p.roi && d != 0 && int'(p.row) < MAX_ROWS && int'(p.col) < MAX_COLS) begin
      ground = longint'(icpt_m) * 256 + longint'(slope_m) * longint'(p.row)
             + longint'(margin_m) * 256;
      if (d * 256 >= ground) begin
        pix_cnt = pix_cnt + 1'b1;
        disp_sum = disp_sum + SUM_W'(d);
        mom_col = mom_col + MOM_W'(d * longint'(p.col));
        mom_row = mom_row + MOM_W'(d * longint'(p.row));
      end
    end
    if (p.last) begin
      res = '0;
      sum = longint'($signed(disp_sum));
      if (pix_cnt != 0 && sum > 0) begin
        range_cm = (longint'(scale_m) * 16 * longint'(pix_cnt)) / sum;
        res.found = 1'b1;
        res.dist_cm = (range_cm > 1048575) ? '1 : DIST_W'(range_cm);
        res.cx = centroid_coord(mom_col, sum, coff_m);
        res.cy = centroid_coord(mom_row, sum, roff_m);
      end
      centroid_q = {centroid_q, res};
      pix_cnt = '0;
      disp_sum = '0;
      mom_col = '0;
      mom_row = '0;
    end
  endfunction

  // one register write over the configuration channel
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SLOPE:     slope_m = val[SLOPE_W-1:0];
      CFG_INTERCEPT: icpt_m = val[PLANE_W-1:0];
      CFG_MARGIN:    margin_m = val[PLANE_W-1:0];
      CFG_COL_OFF:   coff_m = val[OFF_W-1:0];
      CFG_ROW_OFF:   roff_m = val[OFF_W-1:0];
      CFG_SCALE:     scale_m = val[SCALE_W-1:0];
      default:       ;
    endcase
  endtask

  task automatic load_plane(int sl, int ic, int mg, int co, int ro, int sc);
    write_reg(CFG_SLOPE, CFG_DATA_W'(sl));
    write_reg(CFG_INTERCEPT, CFG_DATA_W'(ic));
    write_reg(CFG_MARGIN, CFG_DATA_W'(mg));
    write_reg(CFG_COL_OFF, CFG_DATA_W'(co));
    write_reg(CFG_ROW_OFF, CFG_DATA_W'(ro));
    write_reg(CFG_SCALE, CFG_DATA_W'(sc));
  endtask

  // mostly a plausible ground plane, sometimes anywhere in range
  task automatic random_plane();
    int sl, ic, mg;
    if ($urandom_range(3) == 0) begin
      sl = int'($urandom_range(131071)) - 65536;
      ic = int'($urandom_range(65535)) - 32768;
      mg = int'($urandom_range(65535)) - 32768;
    end else begin
      sl = int'($urandom_range(1024)) - 512;
      ic = int'($urandom_range(400)) - 100;
      mg = int'($urandom_range(100)) - 50;
    end
    load_plane(sl, ic, mg, $urandom_range(4095), $urandom_range(4095),
               $urandom_range(65535, 1));
  endtask

  function automatic void add_px(int d, int row, int col, bit roi, bit last);
    pixel_t p;
    p.disp = DISP_W'(d);
    p.row = POS_W'(row);
    p.col = POS_W'(col);
    p.roi = roi;
    p.last = last;
    pixel_q = {pixel_q, p};
    n_queued++;
  endfunction

  // whole frames: compact blobs or scattered pixels, a few dark frames
  task automatic queue_frames(int n_items);
    int left, len, d, r0, c0, pick;
    bit blob, dark;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(10, 1);
      if (len > left) len = left;
      blob = ($urandom_range(1) == 1);
      dark = ($urandom_range(9) == 0);
      r0 = $urandom_range(1023);
      c0 = $urandom_range(1023);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(99);
        if (pick < 70) d = $urandom_range(1279, 1);
        else if (pick < 80) d = 0;
        else d = -int'($urandom_range(16, 1));
        add_px(d, blob ? r0 + int'($urandom_range(7)) : int'($urandom_range(1023)),
               blob ? c0 + i : int'($urandom_range(1023)),
               dark ? ($urandom_range(4) == 0) : ($urandom_range(9) != 0), i == len - 1);
      end
      left = left - len;
    end
  endtask

  // wait until every pixel is in and every centroid is out
  task automatic drain_block();
    while (n_accepted != n_queued) @(posedge clk);
    while (centroid_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        accumulate_pixel(cur_px);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pixel_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur_px = pixel_q.pop_front();
          in_valid <= 1'b1;
          in_disparity <= cur_px.disp;
          in_row <= cur_px.row;
          in_col <= cur_px.col;
          in_inside_region <= cur_px.roi;
          in_frame_end <= cur_px.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result back-pressure, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (choke_req && !choke_taken) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      choke_taken <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // result monitor
  always @(posedge clk) begin : result_check
    centroid_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (centroid_q.size() == 0) begin
        $display("%0t: unexpected result transfer found=%0d dist=%0d x=%0d y=%0d", $time,
                 out_object_found, out_distance_cm, out_center_x, out_center_y);
        mismatches++;
      end else begin
        want = centroid_q.pop_front();
        if (out_object_found !== want.found) begin
          $display("%0t: object_found expected %0d actual %0d", $time, want.found,
                   out_object_found);
          mismatches++;
        end
        if (out_distance_cm !== want.dist_cm) begin
          $display("%0t: distance_cm expected %0d actual %0d", $time, want.dist_cm,
                   out_distance_cm);
          mismatches++;
        end
        if (out_center_x !== want.cx) begin
          $display("%0t: center_x expected %0d actual %0d", $time, want.cx, out_center_x);
          mismatches++;
        end
        if (out_center_y !== want.cy) begin
          $display("%0t: center_y expected %0d actual %0d", $time, want.cy, out_center_y);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: extreme fields, outside region, zero and below-plane pixels
    add_px(1279, 0, 1023, 1, 0);
    add_px(1, 1023, 0, 1, 1);
    add_px(500, 3, 3, 0, 1);
    add_px(0, 5, 5, 1, 0);
    add_px(-16, 5, 5, 1, 1);
    add_px(640, 512, 512, 1, 1);
    drain_block();

    // plane far below everything: saturation, negative moment, non-positive sums
    load_plane(-65536, -32768, -32768, 4095, 4095, 65535);
    add_px(-1, 10, 10, 1, 0);
    add_px(1, 11, 11, 1, 0);
    add_px(1, 12, 12, 1, 1);
    add_px(100, 1023, 1023, 1, 0);
    add_px(-99, 0, 0, 1, 1);
    add_px(-16, 0, 1023, 1, 0);
    add_px(100, 1023, 0, 1, 1);
    add_px(-16, 0, 0, 1, 1);
    add_px(5, 1, 1, 1, 0);
    add_px(-5, 2, 2, 1, 1);
    drain_block();

    // plane far above everything
    load_plane(65535, 32767, 32767, 0, 0, 0);
    add_px(1279, 0, 0, 1, 1);
    drain_block();

    // exact plane boundary, zero range scale, writes to unused indexes
    load_plane(256, 100, 20, 7, 9, 0);
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, 17'h0aaaa);
    add_px(130, 10, 4, 1, 0);
    add_px(129, 11, 6, 1, 0);
    add_px(1279, 1023, 1023, 1, 1);
    drain_block();

    // random planes and frames
    for (int ph = 0; ph < 10; ph++) begin
      random_plane();
      calm = (ph == 6);
      choke_req = (ph == 3);
      queue_frames(108);
      drain_block();
    end
    calm = 1'b0;

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
